// ===== hdl/ghp_pkg.sv =====
// shared constants for the generational handle pool: sizes, command and status codes
// no dependencies; imported by ghp_free_enc, generational_handle_pool_unit and the testbench
package ghp_pkg;

  localparam int SLOTS   = 64;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int CNT_W   = 7;
  localparam int GEN_W   = 16;
  localparam int DESC_W  = 31;
  localparam int ENTRY_W = GEN_W + DESC_W;

  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

  localparam logic [1:0] CMD_REGISTER = 2'd0;
  localparam logic [1:0] CMD_RELEASE  = 2'd1;
  localparam logic [1:0] CMD_LOOKUP   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_NOENTRY = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

endpackage

// ===== hdl/ghp_free_enc.sv =====
// lowest-free-slot priority encoder over the used flags, limited to the live slot count
// depends on ghp_pkg
module ghp_free_enc (
  input  logic [ghp_pkg::SLOTS-1:0]  used_i,
  input  logic [ghp_pkg::CNT_W-1:0]  live_i,
  output logic                       found_o,
  output logic [ghp_pkg::SLOT_W-1:0] slot_o
);
  import ghp_pkg::*;

  logic [SLOTS-1:0] free;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      free[i] = !used_i[i] && (i < int'(live_i));
    end
  end

  // scan from the top so the lowest free slot wins
  always_comb begin
    found_o = 1'b0;
    slot_o  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (free[i]) begin
        found_o = 1'b1;
        slot_o  = SLOT_W'(i);
      end
    end
  end

endmodule

// ===== hdl/generational_handle_pool_unit.sv =====
// Generational handle pool.
// A command transfer is taken at a rising edge with start high and busy low; cmd_i,
// descriptor_i and handle_in_i are sampled then. Register puts the descriptor in the
// lowest free slot below the active count and answers generation<<16 | (slot+1);
// release checks the handle, answers the descriptor, frees the slot and bumps its
// generation; lookup checks and answers without changing anything.
// Each command gives one result on status_o, handle_out_o, descriptor_out_o and
// slot_index_o, shown for exactly one cycle with done_o high; the receiver cannot
// stall. The result is registered at the edge that ends the busy cycle; busy blocks a
// new command until the read of the slot RAM has been followed by its write-back.
// Slot RAM holds {generation, descriptor}; used flags and generation-valid bits sit in
// flip-flops so reset frees every slot and reads every generation as zero at once.
// active_slots is written through cfg_we_i / cfg_wdata_i and resets to 64.
// depends on ghp_pkg and ghp_free_enc
module generational_handle_pool_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 cmd_i,
  input  logic [ghp_pkg::DESC_W-1:0] descriptor_i,
  input  logic [31:0]                handle_in_i,
  input  logic                       cfg_we_i,
  input  logic [ghp_pkg::CNT_W-1:0]  cfg_wdata_i,
  output logic                       done_o,
  output logic [1:0]                 status_o,
  output logic [31:0]                handle_out_o,
  output logic [ghp_pkg::DESC_W-1:0] descriptor_out_o,
  output logic [ghp_pkg::SLOT_W-1:0] slot_index_o
);
  import ghp_pkg::*;

  logic [CNT_W-1:0]   active_q;
  logic [CNT_W-1:0]   live;
  logic [SLOTS-1:0]   used_q, used_d;
  logic [SLOTS-1:0]   gvld_q, gvld_d;
  logic               busy_q;
  logic               accept;

  logic               enc_found;
  logic [SLOT_W-1:0]  enc_slot;
  logic [15:0]        hidx;
  logic               hidx_ok;
  logic [SLOT_W-1:0]  raddr;

  logic [ENTRY_W-1:0] mem [SLOTS];
  logic [ENTRY_W-1:0] rd_q;
  logic               gvld_rd_q;

  logic [1:0]         cmd_q;
  logic [DESC_W-1:0]  desc_q;
  logic [GEN_W-1:0]   hgen_q;
  logic [SLOT_W-1:0]  slot_q;
  logic               hit_q;

  logic [GEN_W-1:0]   gen_rd;
  logic [DESC_W-1:0]  desc_rd;
  logic               we;
  logic [ENTRY_W-1:0] wdata;
  logic               set_used, clr_used;
  logic [1:0]         status_d;
  logic [31:0]        handle_d;
  logic [DESC_W-1:0]  dout_d;
  logic [SLOT_W-1:0]  sidx_d;

  logic               done_q;
  logic [1:0]         status_q;
  logic [31:0]        handle_q;
  logic [DESC_W-1:0]  dout_q;
  logic [SLOT_W-1:0]  sidx_q;

  assign busy   = busy_q;
  assign accept = start && !busy_q;
  assign live   = (active_q > SLOTS_CNT) ? SLOTS_CNT : active_q;

  ghp_free_enc u_free_enc (
    .used_i  (used_q),
    .live_i  (live),
    .found_o (enc_found),
    .slot_o  (enc_slot)
  );

  // index field zero wraps to 0xffff and always fails the range check
  assign hidx    = handle_in_i[15:0] - 16'd1;
  assign hidx_ok = hidx < {{(16-CNT_W){1'b0}}, live};
  assign raddr   = (cmd_i == CMD_REGISTER) ? enc_slot : hidx[SLOT_W-1:0];

  // slot RAM: registered read at the accepting edge, write-back at the edge after it
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[slot_q] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= cmd_i;
      desc_q    <= descriptor_i;
      hgen_q    <= handle_in_i[31:16];
      slot_q    <= raddr;
      hit_q     <= (cmd_i == CMD_REGISTER) ? enc_found : hidx_ok;
      gvld_rd_q <= gvld_q[raddr];
    end
  end

  assign gen_rd  = gvld_rd_q ? rd_q[ENTRY_W-1:DESC_W] : '0;
  assign desc_rd = rd_q[DESC_W-1:0];

  always_comb begin
    we       = 1'b0;
    wdata    = {gen_rd, desc_rd};
    set_used = 1'b0;
    clr_used = 1'b0;
    status_d = ST_INVALID;
    handle_d = '0;
    dout_d   = '0;
    sidx_d   = '0;
    case (cmd_q)
      CMD_REGISTER: begin
        if (hit_q) begin
          status_d = ST_OK;
          handle_d = {gen_rd, 16'(slot_q) + 16'd1};
          sidx_d   = slot_q;
          we       = 1'b1;
          wdata    = {gen_rd, desc_q};
          set_used = 1'b1;
        end else begin
          status_d = ST_FULL;
        end
      end
      CMD_RELEASE, CMD_LOOKUP: begin
        if (!hit_q) begin
          status_d = ST_INVALID;
        end else if (!used_q[slot_q] || gen_rd != hgen_q) begin
          status_d = ST_NOENTRY;
        end else begin
          status_d = ST_OK;
          dout_d   = desc_rd;
          sidx_d   = slot_q;
          if (cmd_q == CMD_RELEASE) begin
            we       = 1'b1;
            wdata    = {gen_rd + GEN_W'(1), desc_rd};
            clr_used = 1'b1;
          end
        end
      end
      default: begin
        status_d = ST_INVALID;
      end
    endcase
    if (!busy_q) begin
      we       = 1'b0;
      set_used = 1'b0;
      clr_used = 1'b0;
    end
  end

  always_comb begin
    used_d = used_q;
    gvld_d = gvld_q;
    if (set_used) begin
      used_d[slot_q] = 1'b1;
    end
    if (clr_used) begin
      used_d[slot_q] = 1'b0;
    end
    if (we) begin
      gvld_d[slot_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= SLOTS_CNT;
      used_q   <= '0;
      gvld_q   <= '0;
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
      used_q <= used_d;
      gvld_q <= gvld_d;
      busy_q <= accept;
      done_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      status_q <= status_d;
      handle_q <= handle_d;
      dout_q   <= dout_d;
      sidx_q   <= sidx_d;
    end
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign handle_out_o     = handle_q;
  assign descriptor_out_o = dout_q;
  assign slot_index_o     = sidx_q;

endmodule

// ===== dv/tb_generational_handle_pool_unit.sv =====
// testbench for generational_handle_pool_unit: directed and random command transfers
// checked against an in-bench slot pool predictor; depends on ghp_pkg and the rtl
module tb_generational_handle_pool_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ghp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  // how a release or lookup handle gets chosen when the command is issued
  typedef enum logic [1:0] {PICK_RAW, PICK_LIVE, PICK_STALE, PICK_FREE} pick_e;

  typedef struct {
    logic [1:0]        cmd;
    logic [DESC_W-1:0] desc;
    logic [31:0]       handle;
    pick_e             pick;
  } pool_cmd_t;

  typedef struct {
    logic [1:0]        status;
    logic [31:0]       handle;
    logic [DESC_W-1:0] desc;
    logic [SLOT_W-1:0] slot;
  } pool_reply_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         cmd_i = '0;
  logic [DESC_W-1:0]  descriptor_i = '0;
  logic [31:0]        handle_in_i = '0;
  logic               cfg_we_i = 1'b0;
  logic [CNT_W-1:0]   cfg_wdata_i = '0;
  logic               done_o;
  logic [1:0]         status_o;
  logic [31:0]        handle_out_o;
  logic [DESC_W-1:0]  descriptor_out_o;
  logic [SLOT_W-1:0]  slot_index_o;

  generational_handle_pool_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .cmd_i           (cmd_i),
    .descriptor_i    (descriptor_i),
    .handle_in_i     (handle_in_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .handle_out_o    (handle_out_o),
    .descriptor_out_o(descriptor_out_o),
    .slot_index_o    (slot_index_o)
  );

  // predicted pool contents
  bit                pool_used [SLOTS];
  logic [DESC_W-1:0] pool_desc [SLOTS];
  bit   [GEN_W-1:0]  pool_gen  [SLOTS];
  logic [CNT_W-1:0]  pool_active = SLOTS_CNT;

  pool_cmd_t   cmd_feed_q[$];
  pool_reply_t reply_q[$];
  int          idle_pct = 0;
  int          fail_cnt = 0;
  int          cycle_cnt = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int pool_live();
    return (pool_active > SLOTS_CNT) ? SLOTS : int'(pool_active);
  endfunction

  function automatic pool_reply_t pool_predict(logic [1:0] cmd, logic [DESC_W-1:0] desc,
                                               logic [31:0] h);
    pool_reply_t r;
    int          n;
    logic [15:0] idx;
    r = '{ST_INVALID, 32'd0, '0, '0};
    n = pool_live();
    idx = h[15:0] - 16'd1;
    case (cmd)
      CMD_REGISTER: begin
        r.status = ST_FULL;
        for (int i = 0; i < n; i++) begin
          if (!pool_used[i]) begin
            pool_used[i] = 1'b1;
            pool_desc[i] = desc;
            r.status = ST_OK;
            r.handle = {pool_gen[i], 16'(i + 1)};
            r.slot = SLOT_W'(i);
            break;
          end
        end
      end
      CMD_RELEASE, CMD_LOOKUP: begin
        if (int'(idx) >= n) begin
          r.status = ST_INVALID;
        end else if (!pool_used[idx] || pool_gen[idx] != h[31:16]) begin
          r.status = ST_NOENTRY;
        end else begin
          r.status = ST_OK;
          r.desc = pool_desc[idx];
          r.slot = SLOT_W'(idx);
          if (cmd == CMD_RELEASE) begin
            pool_gen[idx] = pool_gen[idx] + 16'd1;
            pool_used[idx] = 1'b0;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // turns a handle recipe into a concrete handle from the pool as it stands now
  function automatic logic [31:0] resolve_handle(pool_cmd_t c);
    int cand[$];
    int n;
    int s;
    n = pool_live();
    if (c.pick == PICK_RAW) return c.handle;
    for (int i = 0; i < n; i++) begin
      if ((c.pick == PICK_FREE) ? !pool_used[i] : pool_used[i]) cand.push_back(i);
    end
    if (cand.size() == 0) return c.handle;
    s = cand[$urandom_range(cand.size() - 1)];
    if (c.pick == PICK_STALE) return {pool_gen[s] - 16'($urandom_range(1, 3)), 16'(s + 1)};
    return {pool_gen[s], 16'(s + 1)};
  endfunction

  // driver: predicts each accepted transfer, then presents the next one
  always @(posedge clk_i) begin
    pool_cmd_t c;
    if (rst_ni) begin
      if (start && !busy) reply_q.push_back(pool_predict(cmd_i, descriptor_i, handle_in_i));
      if (!start || !busy) begin
        if (cmd_feed_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          c = cmd_feed_q.pop_front();
          start <= 1'b1;
          cmd_i <= c.cmd;
          descriptor_i <= c.desc;
          handle_in_i <= resolve_handle(c);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin
    pool_reply_t want;
    if (rst_ni && done_o) begin
      if (reply_q.size() == 0) begin
        $error("unexpected result, status %0d handle %0h", status_o, handle_out_o);
        fail_cnt++;
      end else begin
        want = reply_q.pop_front();
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("handle_out", want.handle, handle_out_o);
        check_field("descriptor_out", 32'(want.desc), 32'(descriptor_out_o));
        check_field("slot_index", 32'(want.slot), 32'(slot_index_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic add_cmd(logic [1:0] cmd, logic [DESC_W-1:0] desc, logic [31:0] handle,
                         pick_e pick);
    cmd_feed_q.push_back('{cmd, desc, handle, pick});
  endtask

  task automatic add_random();
    int                r;
    logic [DESC_W-1:0] d;
    logic [31:0]       h;
    logic [1:0]        rw;
    r = $urandom_range(99);
    d = DESC_W'($urandom());
    if ($urandom_range(9) == 0) d = $urandom_range(1) ? '1 : '0;
    rw = $urandom_range(1) ? CMD_RELEASE : CMD_LOOKUP;
    h = $urandom_range(1) ? $urandom() : {16'($urandom_range(3)), 16'($urandom_range(70))};
    if (r < 35)      add_cmd(CMD_REGISTER, d, h, PICK_RAW);
    else if (r < 55) add_cmd(CMD_RELEASE, d, h, PICK_LIVE);
    else if (r < 75) add_cmd(CMD_LOOKUP, d, h, PICK_LIVE);
    else if (r < 83) add_cmd(rw, d, h, PICK_STALE);
    else if (r < 88) add_cmd(rw, d, h, PICK_FREE);
    else if (r < 95) add_cmd(rw, d, h, PICK_RAW);
    else             add_cmd(2'd3, d, h, PICK_RAW);
  endtask

  // holds off until the pool has answered everything, plus the result latency
  task automatic drain();
    while (cmd_feed_q.size() != 0 || start || reply_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_active(logic [CNT_W-1:0] v);
    drain();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    pool_active = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(logic [CNT_W-1:0] active, int idle, int count);
    set_active(active);
    idle_pct = idle;
    repeat (count) add_random();
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero index, all-ones handle, descriptor extremes, release and reuse
    add_cmd(CMD_LOOKUP, '0, 32'h0000_0000, PICK_RAW);
    add_cmd(CMD_RELEASE, '0, 32'hFFFF_FFFF, PICK_RAW);
    add_cmd(CMD_REGISTER, '0, '0, PICK_RAW);
    add_cmd(CMD_REGISTER, '1, '0, PICK_RAW);
    add_cmd(CMD_LOOKUP, '0, 32'h0000_0001, PICK_RAW);
    add_cmd(2'd3, '1, 32'h0000_0001, PICK_RAW);
    add_cmd(CMD_RELEASE, '0, 32'h0000_0001, PICK_RAW);
    add_cmd(CMD_RELEASE, '0, 32'h0000_0001, PICK_RAW);
    // free slot whose generation matches still reports no entry
    add_cmd(CMD_LOOKUP, '0, 32'h0001_0001, PICK_RAW);
    add_cmd(CMD_REGISTER, 31'h2AAA_5555, '0, PICK_RAW);
    add_cmd(CMD_LOOKUP, '0, 32'h0000_0041, PICK_RAW);
    add_cmd(CMD_LOOKUP, '0, 32'h0000_0040, PICK_RAW);
    add_cmd(CMD_LOOKUP, '0, '0, PICK_STALE);
    add_cmd(CMD_RELEASE, '0, '0, PICK_LIVE);
    add_cmd(CMD_REGISTER, 31'h5555_2AAA, '0, PICK_RAW);
    drain();

    // zero active slots: pool full on register, every handle invalid
    set_active(7'd0);
    add_cmd(CMD_REGISTER, 31'h1234_5678, '0, PICK_RAW);
    add_cmd(CMD_LOOKUP, '0, 32'h0001_0001, PICK_RAW);
    set_active(7'd2);
    add_cmd(CMD_REGISTER, 31'h0000_0001, '0, PICK_RAW);
    add_cmd(CMD_LOOKUP, '0, 32'h0000_0002, PICK_RAW);
    // shrunk count hides a used slot until it grows again
    set_active(7'd1);
    add_cmd(CMD_LOOKUP, '0, 32'h0000_0002, PICK_RAW);
    add_cmd(CMD_REGISTER, 31'h0000_0002, '0, PICK_RAW);
    set_active(7'd127);
    add_cmd(CMD_LOOKUP, '0, 32'h0000_0002, PICK_RAW);
    add_cmd(CMD_LOOKUP, '0, 32'h0000_0041, PICK_RAW);
    drain();

    run_phase(7'd64, 0, 150);
    run_phase(7'd7, 71, 120);
    run_phase(7'd127, 34, 120);
    run_phase(7'd0, 0, 30);
    run_phase(7'd1, 71, 30);
    run_phase(7'd33, 34, 150);
    run_phase(7'd64, 0, 100);

    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
